// ===== design/pea_pkg.sv =====
// ----------------------------------------------------------------------------
// pea_pkg
// Types and constants shared by the page extent allocator.
// ----------------------------------------------------------------------------
package pea_pkg;
  localparam int unsigned AddrW = 36;
  localparam int unsigned LenW  = 20;
  localparam int unsigned StW   = 2;

  localparam logic [StW-1:0] StOk     = 2'd0;
  localparam logic [StW-1:0] StBump   = 2'd1;
  localparam logic [StW-1:0] StReject = 2'd2;
  localparam logic [StW-1:0] StNoRoom = 2'd3;

  localparam logic RegHeapBase  = 1'b0;
  localparam logic RegHeapLimit = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_SHL_REQ,
    S_SHL_WR,
    S_SHR_REQ,
    S_SHR_WR,
    S_INS,
    S_OUT
  } state_e;
endpackage

// ===== design/page_extent_allocator_core.sv =====
// ----------------------------------------------------------------------------
// page_extent_allocator_core
// First-fit free-extent page allocator with a bump region fallback.
// ----------------------------------------------------------------------------
// Usage: requests arrive on s_axis (tdata = req_type, page_addr, page_count);
// one result per request leaves on m_axis (tdata = status, block_page).
// Configuration writes (cfg_*) set heap base (index 0, also reloads the bump
// pointer) and heap limit (index 1); write them only while the block is idle.
// The extent table sits in one synchronous RAM with a registered read port.
// Each request is handled alone: a scan reads one entry per S_SCAN_REQ and
// S_SCAN_CHK pair, and an exact-fit removal or an insert then shifts the
// entries one by one through S_SHL_REQ/S_SHL_WR or S_SHR_REQ/S_SHR_WR.
// The walk and the shift together cover the table at most once. The next
// request is taken once the result is transferred. Reset empties the table
// (count zero) and sets the bump pointer to zero; RAM contents need no
// clearing. If the receiver stalls, the result holds in m_axis_tdata and no
// new request is accepted until it is transferred.
// ----------------------------------------------------------------------------
module page_extent_allocator_core #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [0] req_type, [36:1] page_addr, [56:37] page_count
  input  logic [63:0]              s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [1:0] status, [37:2] block_page
  output logic [39:0]              m_axis_tdata,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [pea_pkg::AddrW-1:0] cfg_data_i
);
  import pea_pkg::*;

  localparam int unsigned IdxW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned EntW = AddrW + LenW;

  logic [EntW-1:0] mem [MAX_EXTENTS];
  logic [EntW-1:0] rd_q;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [AddrW-1:0] bump_q, bump_d, limit_q;
  logic             type_q;
  logic [AddrW-1:0] addr_q;
  logic [LenW-1:0]  cnt_q;
  logic [StW-1:0]   st_q, st_d;
  logic [AddrW-1:0] pg_q, pg_d;
  logic             req_take;

  wire [AddrW-1:0] rd_start = rd_q[AddrW-1:0];
  wire [LenW-1:0]  rd_len   = rd_q[EntW-1:AddrW];
  wire [AddrW:0]   free_end = {1'b0, addr_q} + {{(AddrW+1-LenW){1'b0}}, cnt_q};
  wire [AddrW:0]   bump_end = {1'b0, bump_q} + {{(AddrW+1-LenW){1'b0}}, cnt_q};
  wire [LenW:0]    mrg_len  = {1'b0, rd_len} + {1'b0, cnt_q};
  wire             pos_end  = (pos_q == count_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign req_take      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {2'b00, pg_q, st_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (req_take) state_d = S_SCAN_REQ;
      S_SCAN_REQ: begin
        if (cnt_q == '0) state_d = S_OUT;
        else if (type_q && free_end > {1'b1, {AddrW{1'b0}}}) state_d = S_OUT;
        else if (pos_end) state_d = type_q ? S_SHR_REQ : S_OUT;
        else state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!type_q) begin
          if (rd_len >= cnt_q) state_d = (rd_len == cnt_q) ? S_SHL_REQ : S_OUT;
          else state_d = S_SCAN_REQ;
        end else if (rd_start < addr_q) begin
          state_d = S_SCAN_REQ;
        end else if (rd_start == free_end[AddrW-1:0] && !mrg_len[LenW]) begin
          state_d = S_OUT;
        end else begin
          state_d = S_SHR_REQ;
        end
      end
      S_SHL_REQ:  state_d = (k_q + 1'b1 < count_q) ? S_SHL_WR : S_OUT;
      S_SHL_WR:   state_d = S_SHL_REQ;
      S_SHR_REQ: begin
        if (count_q >= CntW'(MAX_EXTENTS)) state_d = S_OUT;
        else if (k_q > pos_q) state_d = S_SHR_WR;
        else state_d = S_INS;
      end
      S_SHR_WR:   state_d = S_SHR_REQ;
      S_INS:      state_d = S_OUT;
      S_OUT:      if (m_axis_tready) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    k_d     = k_q;
    bump_d  = bump_q;
    st_d    = st_q;
    pg_d    = pg_q;
    we      = 1'b0;
    waddr   = pos_q[IdxW-1:0];
    wdata   = {cnt_q, addr_q};
    raddr   = pos_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        pos_d = '0;
        st_d  = StReject;
        pg_d  = '0;
      end
      S_SCAN_REQ: begin
        k_d = count_q;
        if (cnt_q != '0 && !type_q && pos_end) begin
          if (bump_end > {1'b0, limit_q}) begin
            st_d = StNoRoom;
          end else begin
            st_d   = StBump;
            pg_d   = bump_q;
            bump_d = bump_end[AddrW-1:0];
          end
        end
      end
      S_SCAN_CHK: begin
        if (!type_q) begin
          if (rd_len >= cnt_q) begin
            st_d = StOk;
            pg_d = rd_start;
            k_d  = pos_q;
            if (rd_len != cnt_q) begin
              we    = 1'b1;
              wdata = {rd_len - cnt_q, rd_start + {{(AddrW-LenW){1'b0}}, cnt_q}};
            end
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end else if (rd_start < addr_q) begin
          pos_d = pos_q + 1'b1;
        end else if (rd_start == free_end[AddrW-1:0] && !mrg_len[LenW]) begin
          st_d  = StOk;
          we    = 1'b1;
          wdata = {mrg_len[LenW-1:0], addr_q};
        end
      end
      S_SHL_REQ: begin
        raddr = IdxW'(k_q + 1'b1);
        if (!(k_q + 1'b1 < count_q)) count_d = count_q - 1'b1;
      end
      S_SHL_WR: begin
        we    = 1'b1;
        waddr = k_q[IdxW-1:0];
        wdata = rd_q;
        k_d   = k_q + 1'b1;
      end
      S_SHR_REQ: begin
        raddr = IdxW'(k_q - 1'b1);
        if (count_q >= CntW'(MAX_EXTENTS)) st_d = StNoRoom;
      end
      S_SHR_WR: begin
        we    = 1'b1;
        waddr = k_q[IdxW-1:0];
        wdata = rd_q;
        k_d   = k_q - 1'b1;
      end
      S_INS: begin
        we      = 1'b1;
        st_d    = StOk;
        count_d = count_q + 1'b1;
      end
      S_OUT: ;
      default: ;
    endcase
    if (cfg_valid_i && cfg_index_i == RegHeapBase) bump_d = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      bump_q  <= '0;
      limit_q <= '1;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      bump_q  <= bump_d;
      if (cfg_valid_i && cfg_index_i == RegHeapLimit) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    k_q    <= k_d;
    st_q   <= st_d;
    pg_q   <= pg_d;
    if (req_take) begin
      type_q <= s_axis_tdata[0];
      addr_q <= s_axis_tdata[36:1];
      cnt_q  <= s_axis_tdata[56:37];
    end
  end

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(MAX_EXTENTS);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("extent count overflow");

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

  property p_no_take_busy;
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !s_axis_tready;
  endproperty
  a_no_take_busy: assert property (p_no_take_busy) else $error("request taken while busy");

  property p_bump_grant;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && st_q == StReject |-> pg_q == '0;
  endproperty
  a_bump_grant: assert property (p_bump_grant) else $error("reject with page");
endmodule
